// ===== hw/rtl/bppc_pkg.sv =====
// Shared types and constants for the boiler pump priority controller.
// No dependencies; imported by the input channel interface and every module.
`timescale 1ns / 1ps

package bppc_pkg;

  // Widths of the item fields and registers.
  localparam int unsigned TempW    = 12;
  localparam int unsigned CurW     = 16;
  localparam int unsigned HystW    = 10;
  localparam int unsigned LimitW   = 11;
  localparam int unsigned HoldW    = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  // Working width for temperature sums: one bit over the widest operand.
  localparam int unsigned SumW = TempW + 1;

  // Boiler readings below 1 degree C (16 counts of 1/16 degree) give panic.
  localparam logic signed [SumW-1:0] FrozenLimit = 13'sd16;

  // The seconds counter saturates at its all-ones value.
  localparam logic [HoldW-1:0] HoldMax = '1;

  // Register reset values.
  localparam logic [HystW-1:0]         HystRst        = 10'd32;
  localparam logic [LimitW-1:0]        PanicTempRst   = 11'd1520;
  localparam logic [LimitW-1:0]        CutoffTempRst  = 11'd480;
  localparam logic signed [TempW-1:0]  HeatBelowRst   = 12'sd112;
  localparam logic [CurW-1:0]          MinCurrentRst  = 16'd100;
  localparam logic [HoldW-1:0]         PreferHoldRst  = 17'd21600;

  // Item kinds.
  typedef enum logic [1:0] {
    MODE_EVAL  = 2'd0,
    MODE_PRESS = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HYSTERESIS  = 3'd0,
    CFG_PANIC_TEMP  = 3'd1,
    CFG_CUTOFF_TEMP = 3'd2,
    CFG_HEAT_BELOW  = 3'd3,
    CFG_MIN_CURRENT = 3'd4,
    CFG_PREFER_HOLD = 3'd5
  } cfg_idx_e;

  // Register file contents as seen by the evaluation logic.
  typedef struct packed {
    logic [HystW-1:0]        hysteresis;
    logic [LimitW-1:0]       panic_temp;
    logic [LimitW-1:0]       cutoff_temp;
    logic signed [TempW-1:0] heat_below_outside;
    logic [CurW-1:0]         min_pump_current;
    logic [HoldW-1:0]        prefer_hold_seconds;
  } cfg_t;

  // One input word.
  typedef struct packed {
    logic [1:0]              mode;
    logic signed [TempW-1:0] boiler_temp;
    logic                    boiler_valid;
    logic signed [TempW-1:0] tank_temp;
    logic                    tank_valid;
    logic signed [TempW-1:0] outside_temp;
    logic [CurW-1:0]         water_pump_current;
    logic [CurW-1:0]         heat_pump_current;
  } in_item_t;

  // Controller state carried from one word to the next.
  typedef struct packed {
    logic             water_on;
    logic             heat_on;
    logic             panic_flag;
    logic             force_water;
    logic             force_heat;
    logic             prefer_heat;
    logic [HoldW-1:0] hold_count;
  } state_t;

  // One result word.
  typedef struct packed {
    logic water_pump_on;
    logic heat_pump_on;
    logic alarm;
    logic water_forced;
    logic heat_forced;
    logic heat_preferred;
  } out_item_t;

endpackage

// ===== hw/rtl/bppc_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on bppc_pkg for the field widths.
`timescale 1ns / 1ps

interface bppc_in_if
  import bppc_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [1:0]              mode;
  logic signed [TempW-1:0] boiler_temp;
  logic                    boiler_valid;
  logic signed [TempW-1:0] tank_temp;
  logic                    tank_valid;
  logic signed [TempW-1:0] outside_temp;
  logic [CurW-1:0]         water_pump_current;
  logic [CurW-1:0]         heat_pump_current;

  modport source (
    output valid, mode, boiler_temp, boiler_valid, tank_temp, tank_valid,
           outside_temp, water_pump_current, heat_pump_current,
    input  ready
  );

  modport sink (
    input  valid, mode, boiler_temp, boiler_valid, tank_temp, tank_valid,
           outside_temp, water_pump_current, heat_pump_current,
    output ready
  );
endinterface

interface bppc_out_if;
  logic valid;
  logic ready;
  logic water_pump_on;
  logic heat_pump_on;
  logic alarm;
  logic water_forced;
  logic heat_forced;
  logic heat_preferred;

  modport source (
    output valid, water_pump_on, heat_pump_on, alarm, water_forced, heat_forced,
           heat_preferred,
    input  ready
  );

  modport sink (
    input  valid, water_pump_on, heat_pump_on, alarm, water_forced, heat_forced,
           heat_preferred,
    output ready
  );
endinterface

// ===== hw/rtl/bppc_cfg.sv =====
// Configuration register file of the pump controller.
// Depends on bppc_pkg for the register layout and index codes.
`timescale 1ns / 1ps

module bppc_cfg
  import bppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write; indexes beyond the list are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HYSTERESIS:  cfg_d.hysteresis          = cfg_wdata_i[HystW-1:0];
        CFG_PANIC_TEMP:  cfg_d.panic_temp          = cfg_wdata_i[LimitW-1:0];
        CFG_CUTOFF_TEMP: cfg_d.cutoff_temp         = cfg_wdata_i[LimitW-1:0];
        CFG_HEAT_BELOW:  cfg_d.heat_below_outside  = $signed(cfg_wdata_i[TempW-1:0]);
        CFG_MIN_CURRENT: cfg_d.min_pump_current    = cfg_wdata_i[CurW-1:0];
        CFG_PREFER_HOLD: cfg_d.prefer_hold_seconds = cfg_wdata_i[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Registers come out of reset at their documented defaults.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hysteresis          <= HystRst;
      cfg_q.panic_temp          <= PanicTempRst;
      cfg_q.cutoff_temp         <= CutoffTempRst;
      cfg_q.heat_below_outside  <= HeatBelowRst;
      cfg_q.min_pump_current    <= MinCurrentRst;
      cfg_q.prefer_hold_seconds <= PreferHoldRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/bppc_core.sv =====
// Next-state logic of the pump controller: one word against the current state.
// Purely combinational; depends on bppc_pkg.
`timescale 1ns / 1ps

module bppc_core
  import bppc_pkg::*;
(
  input  in_item_t item_i,
  input  cfg_t     cfg_i,
  input  state_t   st_i,
  output state_t   st_o
);

  logic signed [SumW-1:0] boiler_x, tank_x, outside_x, heat_below_x;
  logic signed [SumW-1:0] hyst_x, panic_x, cold_lim, boiler_hyst;
  logic panic, cold, water_run, heat_run, fw, fh;

  // Temperatures in a common signed width with room for the hysteresis sums.
  assign boiler_x     = $signed({item_i.boiler_temp[TempW-1], item_i.boiler_temp});
  assign tank_x       = $signed({item_i.tank_temp[TempW-1], item_i.tank_temp});
  assign outside_x    = $signed({item_i.outside_temp[TempW-1], item_i.outside_temp});
  assign heat_below_x = $signed({cfg_i.heat_below_outside[TempW-1],
                                 cfg_i.heat_below_outside});
  assign hyst_x       = $signed({{(SumW-HystW){1'b0}}, cfg_i.hysteresis});
  assign panic_x      = $signed({{(SumW-LimitW){1'b0}}, cfg_i.panic_temp});
  assign cold_lim     = $signed({{(SumW-LimitW){1'b0}}, cfg_i.cutoff_temp}) - hyst_x;
  assign boiler_hyst  = boiler_x + hyst_x;

  assign panic = !item_i.boiler_valid || !item_i.tank_valid ||
                 (boiler_x >= panic_x) || (boiler_x < FrozenLimit);
  assign cold  = boiler_x < cold_lim;

  // Current through a pump that is commanded off means someone runs it by hand.
  assign water_run = item_i.water_pump_current > cfg_i.min_pump_current;
  assign heat_run  = item_i.heat_pump_current > cfg_i.min_pump_current;
  assign fw = st_i.force_water || (water_run && !st_i.water_on);
  assign fh = st_i.force_heat || (heat_run && !st_i.heat_on);

  always_comb begin
    st_o = st_i;
    case (mode_e'(item_i.mode))
      MODE_EVAL: begin
        if (panic) begin
          // Panic leaves the force flags and the heating request alone.
          st_o.water_on   = 1'b1;
          st_o.heat_on    = 1'b1;
          st_o.panic_flag = 1'b1;
        end else if (cold) begin
          st_o.panic_flag  = 1'b0;
          st_o.water_on    = 1'b0;
          st_o.heat_on     = 1'b0;
          st_o.force_water = 1'b0;
          st_o.force_heat  = 1'b0;
          if (st_i.hold_count > cfg_i.prefer_hold_seconds) begin
            st_o.prefer_heat = 1'b0;
          end
        end else begin
          st_o.panic_flag  = 1'b0;
          st_o.force_water = fw;
          st_o.force_heat  = fh;
          st_o.hold_count  = '0;
          if ((boiler_hyst > tank_x) || fw) begin
            st_o.water_on = 1'b1;
            st_o.heat_on  = 1'b0;
          end else if ((boiler_hyst < tank_x) || st_i.prefer_heat) begin
            // Heating priority; the heating pump only starts when it is cold outside.
            st_o.water_on = 1'b0;
            if (outside_x < heat_below_x) begin
              st_o.heat_on = 1'b1;
            end
          end
        end
      end
      MODE_PRESS: begin
        st_o.prefer_heat = 1'b1;
        st_o.hold_count  = '0;
      end
      MODE_TICK: begin
        if (st_i.hold_count != HoldMax) begin
          st_o.hold_count = st_i.hold_count + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/boiler_pump_priority_controller.sv =====
// Boiler pump priority controller.
// Words enter on in_if (valid/ready) as evaluations, switch presses or one-second
// ticks; every word gives exactly one result word on out_if carrying the pump
// commands, alarm, force flags and heating preference after that word.
// Six configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, one per clock, with no read-back; indexes six and seven are
// ignored. Write them only while no word is in flight.
// An accepted word waits in the input register; the state update and result
// register take it once the result register is free.
// Throughput is one word per cycle while the receiver takes every result, set by
// the single evaluation stage whose state feeds straight back into itself.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more word; after that in_if.ready drops until the
// result is taken.
// Reset (rst_ni low, asynchronous) clears all controller state, empties both
// registers and loads the registers with their defaults.
// Depends on bppc_pkg, bppc_if, bppc_cfg and bppc_core.
`timescale 1ns / 1ps

module boiler_pump_priority_controller
  import bppc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  bppc_in_if.sink             in_if,
  bppc_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_vld_q;
  state_t    st_q, st_d;
  out_item_t out_q;
  logic      out_vld_q;
  logic      out_free, adv;

  bppc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Handshake: the evaluation stage moves whenever the result register is free.
  assign out_free    = !out_vld_q || out_if.ready;
  assign adv         = in_vld_q && out_free;
  assign in_if.ready = !in_vld_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q.mode               <= in_if.mode;
      in_q.boiler_temp        <= in_if.boiler_temp;
      in_q.boiler_valid       <= in_if.boiler_valid;
      in_q.tank_temp          <= in_if.tank_temp;
      in_q.tank_valid         <= in_if.tank_valid;
      in_q.outside_temp       <= in_if.outside_temp;
      in_q.water_pump_current <= in_if.water_pump_current;
      in_q.heat_pump_current  <= in_if.heat_pump_current;
    end
  end

  bppc_core u_core (
    .item_i (in_q),
    .cfg_i  (cfg),
    .st_i   (st_q),
    .st_o   (st_d)
  );

  // Controller state advances once per word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.water_pump_on  <= st_d.water_on;
      out_q.heat_pump_on   <= st_d.heat_on;
      out_q.alarm          <= st_d.panic_flag;
      out_q.water_forced   <= st_d.force_water;
      out_q.heat_forced    <= st_d.force_heat;
      out_q.heat_preferred <= st_d.prefer_heat;
    end
  end

  assign out_if.valid          = out_vld_q;
  assign out_if.water_pump_on  = out_q.water_pump_on;
  assign out_if.heat_pump_on   = out_q.heat_pump_on;
  assign out_if.alarm          = out_q.alarm;
  assign out_if.water_forced   = out_q.water_forced;
  assign out_if.heat_forced    = out_q.heat_forced;
  assign out_if.heat_preferred = out_q.heat_preferred;

  // While the alarm stands, both pumps must be commanded on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.panic_flag |-> (st_q.water_on && st_q.heat_on))
    else $error("alarm set without both pumps on");

  // State only moves when a word passes the evaluation stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("controller state changed without a word");

  // A switch press leaves a fresh heating request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_q.mode == MODE_PRESS)) |=> (st_q.prefer_heat && (st_q.hold_count == '0)))
    else $error("switch press did not refresh the heating request");

  // A tick never makes the seconds counter go backwards.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (in_q.mode == MODE_TICK)) |=> (st_q.hold_count >= $past(st_q.hold_count)))
    else $error("seconds counter went backwards on a tick");

endmodule
